### rtl/polar_peak_clip_excess_core_defines.svh
// ----------------------------------------------------------------------------
// Polar peak clip excess core: assertion macros
// Shared concurrent assertion macros. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef POLAR_PEAK_CLIP_EXCESS_CORE_DEFINES_SVH
`define POLAR_PEAK_CLIP_EXCESS_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define PPCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PPCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PPCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PPCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/ppce_pkg.sv
// ----------------------------------------------------------------------------
// Polar peak clip excess package
// Widths, constants, direction tables and the vector beat type.
// ----------------------------------------------------------------------------
package ppce_pkg;

    localparam int SampleW  = 16;
    localparam int ThrW     = 15;
    localparam int AbsW     = SampleW + 1;
    localparam int VecW     = SampleW + 3;
    localparam int SqW      = 2 * SampleW - 1;
    localparam int ThrSqW   = 2 * ThrW;
    localparam int IdxW     = 6;
    localparam int TabDepth = 64;
    localparam int StepW    = 3;
    localparam int NumCells = 5;
    localparam int MagGain  = 311;
    localparam int MagShift = 9;
    localparam int GainW    = 10;
    localparam int MagW     = 18;
    localparam int CsW      = SampleW + 1;
    localparam int Q15Shift = 15;

    localparam logic [ThrW-1:0]   ThreshReset   = ThrW'(11626);
    localparam logic [ThrSqW-1:0] ThreshSqReset = ThrSqW'(11626 * 11626);

    localparam logic signed [SampleW-1:0] TabC [TabDepth] = '{
        -16'sd4613, 16'sd32442, 16'sd23186, 16'sd23155, 16'sd11197, 16'sd30796,
        16'sd31355, 16'sd9520, 16'sd3515, 16'sd32579, 16'sd28172, 16'sd16736,
        16'sd18433, 16'sd27092, 16'sd32733, 16'sd1509,
        -16'sd538, 16'sd32764, 16'sd25888, 16'sd20088, 16'sd14944, 16'sd29162,
        16'sd32296, 16'sd5542, 16'sd7544, 16'sd31888, 16'sd30037, 16'sd13098,
        16'sd21662, 16'sd24586, 16'sd32666, -16'sd2578,
        -16'sd2578, 16'sd32666, 16'sd24586, 16'sd21662, 16'sd13098, 16'sd30037,
        16'sd31888, 16'sd7544, 16'sd5542, 16'sd32296, 16'sd29162, 16'sd14944,
        16'sd20088, 16'sd25888, 16'sd32764, -16'sd538,
        16'sd1509, 16'sd32733, 16'sd27092, 16'sd18433, 16'sd16736, 16'sd28172,
        16'sd32579, 16'sd3515, 16'sd9520, 16'sd31355, 16'sd30796, 16'sd11197,
        16'sd23155, 16'sd23186, 16'sd32442, -16'sd4613
    };

    localparam logic signed [SampleW-1:0] TabS [TabDepth] = '{
        -16'sd32442, -16'sd4613, -16'sd23155, 16'sd23186, -16'sd30796, 16'sd11197,
        -16'sd9520, 16'sd31355, -16'sd32579, 16'sd3515, -16'sd16736, 16'sd28172,
        -16'sd27092, 16'sd18433, -16'sd1509, 16'sd32733,
        -16'sd32764, -16'sd538, -16'sd20088, 16'sd25888, -16'sd29162, 16'sd14944,
        -16'sd5542, 16'sd32296, -16'sd31888, 16'sd7544, -16'sd13098, 16'sd30037,
        -16'sd24586, 16'sd21662, 16'sd2578, 16'sd32666,
        -16'sd32666, -16'sd2578, -16'sd21662, 16'sd24586, -16'sd30037, 16'sd13098,
        -16'sd7544, 16'sd31888, -16'sd32296, 16'sd5542, -16'sd14944, 16'sd29162,
        -16'sd25888, 16'sd20088, 16'sd538, 16'sd32764,
        -16'sd32733, 16'sd1509, -16'sd18433, 16'sd27092, -16'sd28172, 16'sd16736,
        -16'sd3515, 16'sd32579, -16'sd31355, 16'sd9520, -16'sd11197, 16'sd30796,
        -16'sd23186, 16'sd23155, 16'sd4613, 16'sd32442
    };

    // One vector beat as it walks down the rotation chain.
    typedef struct packed {
        logic signed [VecW-1:0] x;
        logic signed [VecW-1:0] y;
        logic [IdxW-1:0]        idx;
        logic                   swap;
        logic                   neg_i;
        logic                   neg_q;
        logic                   last;
        logic [SqW-1:0]         re_sq;
        logic [SqW-1:0]         im_sq;
    } ppce_vec_t;

endpackage

### rtl/ppce_if.sv
// ----------------------------------------------------------------------------
// Polar peak clip excess channel interfaces
// Sample input, result output and threshold write channels.
// ----------------------------------------------------------------------------
interface ppce_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ppce_pkg::SampleW-1:0]   sample_real;
    logic signed [ppce_pkg::SampleW-1:0]   sample_imag;
    logic                                  sample_last;

    modport source (output valid, output sample_real, output sample_imag,
                    output sample_last, input ready);
    modport sink   (input valid, input sample_real, input sample_imag,
                    input sample_last, output ready);
endinterface

interface ppce_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ppce_pkg::SampleW-1:0]   out_real;
    logic signed [ppce_pkg::SampleW-1:0]   out_imag;
    logic                                  out_last;

    modport source (output valid, output out_real, output out_imag,
                    output out_last, input ready);
    modport sink   (input valid, input out_real, input out_imag,
                    input out_last, output ready);
endinterface

interface ppce_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ppce_pkg::ThrW-1:0]          data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/polar_peak_clip_excess_core.sv
// ----------------------------------------------------------------------------
// Polar peak clip excess core
// Streams complex samples and returns the excess of each over a polar clip level.
// ----------------------------------------------------------------------------
// Pipeline: nine register stages, the front, the five cells and back stages A, B and C.
// Throughput: one sample beat per cycle while the output is not stalled; every stage
// is a register with its own valid bit, so each shift-add cell and each back-end stage
// takes a new beat every cycle unless the stage after it is full and stalled.
// A stalled output only holds the stages that are full; bubbles close up upstream.
// Reset clears all valid bits and loads the clip threshold with 11626; no clearing pass.
// ----------------------------------------------------------------------------
module polar_peak_clip_excess_core (
    input  logic            clk,
    input  logic            rst_n,
    ppce_sample_if.sink     sample,
    ppce_result_if.source   result,
    ppce_cfg_if.sink        cfg
);
    import ppce_pkg::*;

    // The data path is a straight pipeline:
    //   front  - folds the sample into the first octant: |I|+|Q| becomes X,
    //            the signed difference becomes Y, and the two squares are formed
    //            for the power test later on.
    //   cells  - five identical shift-add vectoring cells, step k shifting by k.
    //            Each one rotates (X, Y) toward the axis and records the sign of
    //            Y as one bit of the direction index.
    //   back   - scales X by 311/512 to a magnitude, looks up the unit vector
    //            from the direction index, tests power against the squared
    //            threshold, then multiplies the excess magnitude by the unit
    //            vector in Q15 and wraps to 16 bits.

    // Threshold register and its square. The square is computed from the write data so that
    // both change on the same edge. Write only while idle; the block does not enforce it.
    logic [ThrW-1:0]   thr_reg;
    logic [ThrW-1:0]   thr_next;
    logic [ThrSqW-1:0] thr_sq_reg;
    logic [ThrSqW-1:0] thr_sq_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        thr_next    = thr_reg;
        thr_sq_next = thr_sq_reg;
        if (cfg.valid)
        begin
            thr_next    = cfg.data;
            thr_sq_next = ThrSqW'(cfg.data) * ThrSqW'(cfg.data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= ThreshReset;
            thr_sq_reg <= ThreshSqReset;
        end
        else
        begin
            thr_reg    <= thr_next;
            thr_sq_reg <= thr_sq_next;
        end
    end

    // Chain links: link k carries the beat into cell k (link 0 from the front),
    // and chain_ready[k] is the ready of whoever consumes link k.
    ppce_vec_t               chain_data  [NumCells+1];
    logic [NumCells:0]       chain_valid;
    logic [NumCells:0]       chain_ready;

    ppce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar g = 0; g < NumCells; g++)
    begin : g_cell
        ppce_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (StepW'(g + 1)),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    ppce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .thr      (thr_reg),
        .thr_sq   (thr_sq_reg),
        .in_valid (chain_valid[NumCells]),
        .in_ready (chain_ready[NumCells]),
        .in_data  (chain_data[NumCells]),
        .result   (result)
    );

endmodule

### rtl/ppce_front.sv
// ----------------------------------------------------------------------------
// Polar peak clip excess front stage
// Folds the sample into the first octant and forms the two squares.
// ----------------------------------------------------------------------------
`include "polar_peak_clip_excess_core_defines.svh"

module ppce_front (
    input  logic                  clk,
    input  logic                  rst_n,
    ppce_sample_if.sink           sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ppce_pkg::ppce_vec_t   out_data
);
    import ppce_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    ppce_vec_t                 data_reg;
    ppce_vec_t                 data_next;
    logic                      take;
    logic signed [AbsW-1:0]    re_ext;
    logic signed [AbsW-1:0]    im_ext;
    logic [AbsW-1:0]           abs_re;
    logic [AbsW-1:0]           abs_im;
    logic signed [2*SampleW-1:0] re_prod;
    logic signed [2*SampleW-1:0] im_prod;

    assign sample.ready = !valid_reg || out_ready;
    assign take         = sample.valid && sample.ready;

    always_comb
    begin
        re_ext  = AbsW'(sample.sample_real);
        im_ext  = AbsW'(sample.sample_imag);
        abs_re  = re_ext[AbsW-1] ? AbsW'(-re_ext) : AbsW'(re_ext);
        abs_im  = im_ext[AbsW-1] ? AbsW'(-im_ext) : AbsW'(im_ext);
        re_prod = (2*SampleW)'(sample.sample_real) * (2*SampleW)'(sample.sample_real);
        im_prod = (2*SampleW)'(sample.sample_imag) * (2*SampleW)'(sample.sample_imag);

        data_next.swap  = (abs_re <= abs_im);
        data_next.neg_i = re_ext[AbsW-1];
        data_next.neg_q = im_ext[AbsW-1];
        data_next.last  = sample.sample_last;
        data_next.x     = signed'(VecW'(abs_re) + VecW'(abs_im));
        data_next.y     = data_next.swap ? signed'(VecW'(abs_re) - VecW'(abs_im))
                                         : signed'(VecW'(abs_im) - VecW'(abs_re));
        data_next.idx   = IdxW'(1);
        data_next.re_sq = re_prod[SqW-1:0];
        data_next.im_sq = im_prod[SqW-1:0];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (sample.ready)
        begin
            valid_next = sample.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // After a fold with |I| <= |Q| the difference term can never be positive.
    `PPCE_ASSERT_IMP(a_front_swap_sign, clk, rst_n, valid_reg && data_reg.swap, data_reg.y[VecW-1] || (data_reg.y == '0), "front: swapped fold left a positive difference")

endmodule

### rtl/ppce_cell.sv
// ----------------------------------------------------------------------------
// Polar peak clip excess rotation cell
// One shift-add vectoring step with its own output register.
// ----------------------------------------------------------------------------
`include "polar_peak_clip_excess_core_defines.svh"

module ppce_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ppce_pkg::StepW-1:0]  step,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ppce_pkg::ppce_vec_t         in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ppce_pkg::ppce_vec_t         out_data
);
    import ppce_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    ppce_vec_t               data_reg;
    ppce_vec_t               data_next;
    logic                    take;
    logic                    y_pos;
    logic signed [VecW-1:0]  x_sh;
    logic signed [VecW-1:0]  y_sh;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        y_pos     = !in_data.y[VecW-1];
        x_sh      = in_data.x >>> step;
        y_sh      = in_data.y >>> step;
        data_next = in_data;
        if (y_pos)
        begin
            data_next.x   = in_data.x + y_sh;
            data_next.y   = in_data.y - x_sh;
            data_next.idx = in_data.idx | (IdxW'(1) << step);
        end
        else
        begin
            data_next.x = in_data.x - y_sh;
            data_next.y = in_data.y + x_sh;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // The first direction bit is always set and X only grows, so it never goes negative.
    `PPCE_ASSERT_IMP(a_cell_idx_lsb, clk, rst_n, valid_reg, data_reg.idx[0], "cell: direction index lost its low bit")
    `PPCE_ASSERT_IMP(a_cell_x_pos, clk, rst_n, valid_reg, !data_reg.x[VecW-1], "cell: X went negative")
    // A held beat is not dropped while the next cell is stalled.
    `PPCE_ASSERT_NXT(a_cell_hold, clk, rst_n, valid_reg && !out_ready, valid_reg, "cell: stalled beat vanished")

endmodule

### rtl/ppce_back.sv
// ----------------------------------------------------------------------------
// Polar peak clip excess back end
// Magnitude scaling, direction lookup, threshold test and excess products.
// ----------------------------------------------------------------------------
`include "polar_peak_clip_excess_core_defines.svh"

module ppce_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ppce_pkg::ThrW-1:0]    thr,
    input  logic [ppce_pkg::ThrSqW-1:0]  thr_sq,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ppce_pkg::ppce_vec_t          in_data,
    ppce_result_if.source                result
);
    import ppce_pkg::*;

    // Stage A: scaled magnitude, unit vector and threshold decision.
    logic                     va_reg;
    logic                     va_next;
    logic                     ready_a;
    logic signed [MagW-1:0]   mag_a_reg;
    logic signed [CsW-1:0]    cs_re_a_reg;
    logic signed [CsW-1:0]    cs_im_a_reg;
    logic                     above_a_reg;
    logic                     last_a_reg;
    // Stage B: magnitude excess over the threshold.
    logic                     vb_reg;
    logic                     vb_next;
    logic                     ready_b;
    logic signed [MagW-1:0]   diff_b_reg;
    logic signed [CsW-1:0]    cs_re_b_reg;
    logic signed [CsW-1:0]    cs_im_b_reg;
    logic                     above_b_reg;
    logic                     last_b_reg;
    // Stage C: output register.
    logic                     vc_reg;
    logic                     vc_next;
    logic                     ready_c;
    logic signed [SampleW-1:0] out_re_reg;
    logic signed [SampleW-1:0] out_im_reg;
    logic                     last_c_reg;

    logic signed [VecW+GainW-1:0] mag_prod;
    logic signed [MagW-1:0]       mag_next;
    logic [SqW:0]                 sq_sum;
    logic                         above_next;
    logic signed [SampleW-1:0]    tab_re;
    logic signed [SampleW-1:0]    tab_im;
    logic signed [CsW-1:0]        cs_re_next;
    logic signed [CsW-1:0]        cs_im_next;
    logic signed [MagW-1:0]       diff_next;
    logic signed [MagW+CsW-1:0]   prod_re;
    logic signed [MagW+CsW-1:0]   prod_im;
    logic signed [SampleW-1:0]    out_re_next;
    logic signed [SampleW-1:0]    out_im_next;

    assign ready_c  = !vc_reg || result.ready;
    assign ready_b  = !vb_reg || ready_c;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    always_comb
    begin
        mag_prod   = (VecW+GainW)'(in_data.x) * (VecW+GainW)'(MagGain);
        mag_next   = mag_prod[MagW+MagShift-1:MagShift];
        sq_sum     = (SqW+1)'(in_data.re_sq) + (SqW+1)'(in_data.im_sq);
        above_next = sq_sum > (SqW+1)'(thr_sq);
        tab_re     = in_data.swap ? TabS[in_data.idx] : TabC[in_data.idx];
        tab_im     = in_data.swap ? TabC[in_data.idx] : TabS[in_data.idx];
        cs_re_next = in_data.neg_i ? -CsW'(tab_re) : CsW'(tab_re);
        cs_im_next = in_data.neg_q ? -CsW'(tab_im) : CsW'(tab_im);
    end

    always_comb
    begin
        diff_next = mag_a_reg - signed'(MagW'(thr));
    end

    always_comb
    begin
        prod_re     = (MagW+CsW)'(diff_b_reg) * (MagW+CsW)'(cs_re_b_reg);
        prod_im     = (MagW+CsW)'(diff_b_reg) * (MagW+CsW)'(cs_im_b_reg);
        out_re_next = above_b_reg ? prod_re[Q15Shift+SampleW-1:Q15Shift] : '0;
        out_im_next = above_b_reg ? prod_im[Q15Shift+SampleW-1:Q15Shift] : '0;
    end

    always_comb
    begin
        va_next = ready_a ? in_valid : va_reg;
        vb_next = ready_b ? va_reg : vb_reg;
        vc_next = ready_c ? vb_reg : vc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vc_reg <= vc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ready_a)
        begin
            mag_a_reg   <= mag_next;
            cs_re_a_reg <= cs_re_next;
            cs_im_a_reg <= cs_im_next;
            above_a_reg <= above_next;
            last_a_reg  <= in_data.last;
        end
        if (va_reg && ready_b)
        begin
            diff_b_reg  <= diff_next;
            cs_re_b_reg <= cs_re_a_reg;
            cs_im_b_reg <= cs_im_a_reg;
            above_b_reg <= above_a_reg;
            last_b_reg  <= last_a_reg;
        end
        if (vb_reg && ready_c)
        begin
            out_re_reg <= out_re_next;
            out_im_reg <= out_im_next;
            last_c_reg <= last_b_reg;
        end
    end

    assign result.valid    = vc_reg;
    assign result.out_real = out_re_reg;
    assign result.out_imag = out_im_reg;
    assign result.out_last = last_c_reg;

    // The scaled magnitude is never negative.
    `PPCE_ASSERT_IMP(a_back_mag_pos, clk, rst_n, va_reg, !mag_a_reg[MagW-1], "back: negative magnitude")
    // A beat at or below threshold must leave the output stage as zero.
    `PPCE_ASSERT_NXT(a_back_zero, clk, rst_n, vb_reg && ready_c && !above_b_reg, (out_re_reg == '0) && (out_im_reg == '0), "back: below-threshold beat not zeroed")

endmodule
